// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, sampled on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hw/rtl/drct_pkg.sv
// ----------------------------------------------------------------------------
// drct_pkg
// Shared types and constants of the digest reference count table.
// ----------------------------------------------------------------------------
package drct_pkg;

  localparam int KEY_W        = 256;
  localparam int CMD_W        = 2;
  localparam int STATUS_W     = 2;
  localparam int REF_COUNT_W  = 32;
  localparam int OCCUPANCY_W  = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_INC = 2'd0,
    CMD_GET = 2'd1,
    CMD_DEC = 2'd2
  } cmd_e_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_MISSING   = 2'd1,
    STATUS_FULL      = 2'd2,
    STATUS_SATURATED = 2'd3
  } status_e_t;

  typedef struct packed {
    logic   free;
    logic   hit;
  } chain_t;

  typedef struct packed {
    logic   capture;
    logic   apply;
    logic   miss;
    cmd_e_t cmd;
  } req_t;

endpackage

// File: hw/rtl/drct_cell.sv
// ----------------------------------------------------------------------------
// drct_cell
// One table entry: key, count and valid mark, with its match flag and the
// free and hit links to the next cell of the row.
// ----------------------------------------------------------------------------
module drct_cell import drct_pkg::*; #(
  parameter int COUNT_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  req_t                  req,
  input  logic [KEY_W-1:0]      key_in,
  input  chain_t                chain_in,
  output chain_t                chain_out,
  input  logic [COUNT_BITS-1:0] count_in,
  output logic [COUNT_BITS-1:0] count_out
);

  logic                  valid;
  logic                  hit;
  logic [KEY_W-1:0]      key;
  logic [COUNT_BITS-1:0] count;
  logic                  insert;

  assign insert = !valid && !chain_in.free && req.miss && (req.cmd == CMD_INC);

  assign chain_out.free = chain_in.free || !valid;
  assign chain_out.hit  = chain_in.hit || hit;
  assign count_out      = count_in | (hit ? count : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      hit   <= 1'b0;
    end else begin
      if (req.capture) begin
        hit <= valid && (key == key_in);
      end
      if (req.apply) begin
        if (insert) begin
          valid <= 1'b1;
        end else if (hit && (req.cmd == CMD_DEC) && (count == COUNT_BITS'(1))) begin
          valid <= 1'b0;
        end
      end
    end
  end

  // free cells take every key; only the chosen one is marked valid
  always_ff @(posedge clk) begin
    if (req.capture && !valid) begin
      key <= key_in;
    end
    if (req.apply) begin
      if (insert) begin
        count <= COUNT_BITS'(1);
      end else if (hit) begin
        case (req.cmd)
          CMD_INC: begin
            if (count != '1) begin
              count <= count + COUNT_BITS'(1);
            end
          end
          CMD_DEC: begin
            count <= count - COUNT_BITS'(1);
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

// File: hw/rtl/digest_reference_count_table_top.sv
// ----------------------------------------------------------------------------
// digest_reference_count_table_top
// Reference count table keyed by 256-bit digests, one cell per entry.
//
//   channel | signals                                   | dir
//   --------+-------------------------------------------+-----
//   in      | in_valid in_ready command key_word0..3    | in
//   out     | out_valid out_ready status ref_count      | out
//           | occupancy                                 |
//
// The accept edge registers the key match in every cell; the apply edge in
// S_UPDATE then applies the update along the cell row and loads the result
// register. The update waits while the result register holds an untaken
// result. Reset clears the valid marks and the live entry count.
// ----------------------------------------------------------------------------
module digest_reference_count_table_top import drct_pkg::*; #(
  parameter int ENTRIES    = 16,
  parameter int COUNT_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [CMD_W-1:0]       command,
  input  logic [63:0]            key_word0,
  input  logic [63:0]            key_word1,
  input  logic [63:0]            key_word2,
  input  logic [63:0]            key_word3,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [STATUS_W-1:0]    status,
  output logic [REF_COUNT_W-1:0] ref_count,
  output logic [OCCUPANCY_W-1:0] occupancy
);

  localparam int OCC_W = $clog2(ENTRIES + 1);
  localparam int RW    = (COUNT_BITS > REF_COUNT_W) ? COUNT_BITS : REF_COUNT_W;
  localparam int OW    = (OCC_W > OCCUPANCY_W) ? OCC_W : OCCUPANCY_W;

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_UPDATE = 2'b10
  } state_t;

  state_t                state;
  cmd_e_t                cmd;
  logic [OCC_W-1:0]      live;
  logic [OCC_W-1:0]      live_next;
  status_e_t             status_next;
  logic [COUNT_BITS-1:0] count_next;
  logic [RW-1:0]         count_wide;
  logic [OW-1:0]         occ_wide;
  logic                  accept;
  logic                  apply;
  req_t                  req;
  logic [KEY_W-1:0]      key_in;
  chain_t                link [ENTRIES+1];
  logic [COUNT_BITS-1:0] count_link [ENTRIES+1];
  logic [COUNT_BITS-1:0] count_old;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign apply    = (state == S_UPDATE) && (!out_valid || out_ready);
  assign key_in   = {key_word3, key_word2, key_word1, key_word0};

  assign req.capture = accept;
  assign req.apply   = apply;
  assign req.miss    = !link[ENTRIES].hit;
  assign req.cmd     = cmd;

  assign link[0]       = '0;
  assign count_link[0] = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    drct_cell #(
      .COUNT_BITS (COUNT_BITS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .req       (req),
      .key_in    (key_in),
      .chain_in  (link[i]),
      .chain_out (link[i+1]),
      .count_in  (count_link[i]),
      .count_out (count_link[i+1])
    );
  end

  assign count_old = count_link[ENTRIES];

  always_comb begin
    status_next = STATUS_OK;
    count_next  = '0;
    live_next   = live;
    case (cmd)
      CMD_INC: begin
        if (link[ENTRIES].hit) begin
          if (count_old == '1) begin
            status_next = STATUS_SATURATED;
            count_next  = count_old;
          end else begin
            count_next = count_old + COUNT_BITS'(1);
          end
        end else if (link[ENTRIES].free) begin
          count_next = COUNT_BITS'(1);
          live_next  = live + OCC_W'(1);
        end else begin
          status_next = STATUS_FULL;
        end
      end
      CMD_GET: begin
        if (link[ENTRIES].hit) begin
          count_next = count_old;
        end else begin
          status_next = STATUS_MISSING;
        end
      end
      CMD_DEC: begin
        if (link[ENTRIES].hit) begin
          count_next = count_old - COUNT_BITS'(1);
          if (count_old == COUNT_BITS'(1)) begin
            live_next = live - OCC_W'(1);
          end
        end else begin
          status_next = STATUS_MISSING;
        end
      end
      default: begin
      end
    endcase
  end

  assign count_wide = RW'(count_next);
  assign occ_wide   = OW'(live_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      live      <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          if (apply) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (apply) begin
        live      <= live_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= cmd_e_t'(command);
    end
    if (apply) begin
      status    <= status_next;
      ref_count <= count_wide[REF_COUNT_W-1:0];
      occupancy <= occ_wide[OCCUPANCY_W-1:0];
    end
  end

endmodule

// File: hw/rtl/drct_checker.sv
// ----------------------------------------------------------------------------
// drct_checker
// Port-level checks of the digest reference count table, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module drct_checker import drct_pkg::*; #(
  parameter int ENTRIES = 16
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [STATUS_W-1:0]    status,
  input logic [REF_COUNT_W-1:0] ref_count,
  input logic [OCCUPANCY_W-1:0] occupancy
);

  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `ASSERT_IMPL(a_occ_bound, out_valid, (ENTRIES > 31) || (occupancy <= ENTRIES))
  `ASSERT_IMPL(a_full_zero, out_valid && (status == STATUS_FULL), ref_count == '0)
  `ASSERT_IMPL(a_miss_zero, out_valid && (status == STATUS_MISSING), ref_count == '0)
  `ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

endmodule

bind digest_reference_count_table_top drct_checker #(
  .ENTRIES (ENTRIES)
) u_drct_checker (.*);

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for digest_reference_count_table_top.
//
// Drives 256-bit digest requests (increment, get, decrement and the unused
// command code) through a valid/ready channel and checks every result
// against a shadow table kept in the bench, or against written-in outcomes
// for typed rows. A short directed plan covers the empty table, absent keys,
// single-bit key differences, freeing on decrement and the full table.
// Random traffic follows in blocks that lean toward filling or draining the
// table, over a small pool of digests. Both channels idle at random.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import drct_pkg::*;

  localparam int ENTRIES      = 16;
  localparam int COUNT_BITS   = 32;
  localparam int POOL_SIZE    = 20;
  localparam int BLOCK_ITEMS  = 150;
  localparam int RANDOM_ITEMS = 1850;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 8;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef logic [KEY_W-1:0] digest_t;

  localparam digest_t K_ZERO = '0;
  localparam digest_t K_ONES = '1;
  localparam digest_t K_A    = {4{64'h0123_4567_89ab_cdef}};

  typedef struct packed {
    status_e_t                status;
    logic [REF_COUNT_W-1:0]   count;
    logic [OCCUPANCY_W-1:0]   occupancy;
  } outcome_t;

  typedef struct {
    logic [CMD_W-1:0] cmd;
    digest_t          digest;
    bit               typed;
    outcome_t         outcome;
  } plan_row_t;

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_ready;
  logic [CMD_W-1:0]       command;
  logic [63:0]            key_word0;
  logic [63:0]            key_word1;
  logic [63:0]            key_word2;
  logic [63:0]            key_word3;
  logic                   out_valid;
  logic                   out_ready;
  logic [STATUS_W-1:0]    status;
  logic [REF_COUNT_W-1:0] ref_count;
  logic [OCCUPANCY_W-1:0] occupancy;

  digest_t                shadow_keys [ENTRIES];
  logic [COUNT_BITS-1:0]  shadow_counts [ENTRIES];
  bit                     shadow_live [ENTRIES];
  int                     shadow_occupancy = 0;

  outcome_t  pending_outcomes [$];
  plan_row_t directed_plan [$];
  digest_t   key_pool [POOL_SIZE];
  outcome_t  expected_outcome;

  int errors      = 0;
  int idle_cycles = 0;
  int stall_left  = 0;

  digest_reference_count_table_top #(
    .ENTRIES    (ENTRIES),
    .COUNT_BITS (COUNT_BITS)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .key_word0 (key_word0),
    .key_word1 (key_word1),
    .key_word2 (key_word2),
    .key_word3 (key_word3),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .ref_count (ref_count),
    .occupancy (occupancy)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      return 0;
    end else if (roll < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic outcome_t predict(input logic [CMD_W-1:0] cmd, input digest_t digest);
    outcome_t res;
    int       hit;
    int       slot;
    res.status = STATUS_OK;
    res.count  = '0;
    hit        = -1;
    slot       = -1;
    for (int e = 0; e < ENTRIES; e++) begin
      if ((hit < 0) && shadow_live[e] && (shadow_keys[e] == digest)) begin
        hit = e;
      end
      if ((slot < 0) && !shadow_live[e]) begin
        slot = e;
      end
    end
    case (cmd)
      CMD_INC: begin
        if (hit >= 0) begin
          if (shadow_counts[hit] == '1) begin
            res.status = STATUS_SATURATED;
          end else begin
            shadow_counts[hit] = shadow_counts[hit] + COUNT_BITS'(1);
          end
          res.count = REF_COUNT_W'(shadow_counts[hit]);
        end else if (slot >= 0) begin
          shadow_keys[slot]   = digest;
          shadow_counts[slot] = COUNT_BITS'(1);
          shadow_live[slot]   = 1'b1;
          shadow_occupancy++;
          res.count = REF_COUNT_W'(1);
        end else begin
          res.status = STATUS_FULL;
        end
      end
      CMD_GET: begin
        if (hit >= 0) begin
          res.count = REF_COUNT_W'(shadow_counts[hit]);
        end else begin
          res.status = STATUS_MISSING;
        end
      end
      CMD_DEC: begin
        if (hit >= 0) begin
          shadow_counts[hit] = shadow_counts[hit] - COUNT_BITS'(1);
          res.count = REF_COUNT_W'(shadow_counts[hit]);
          if (shadow_counts[hit] == '0) begin
            shadow_live[hit] = 1'b0;
            shadow_occupancy--;
          end
        end else begin
          res.status = STATUS_MISSING;
        end
      end
      default: begin
      end
    endcase
    res.occupancy = OCCUPANCY_W'(shadow_occupancy);
    return res;
  endfunction

  function automatic void add_row(input logic [CMD_W-1:0] cmd, input digest_t digest);
    plan_row_t row;
    row.cmd     = cmd;
    row.digest  = digest;
    row.typed   = 1'b0;
    row.outcome = '0;
    directed_plan.push_back(row);
  endfunction

  function automatic void add_typed(input logic [CMD_W-1:0] cmd, input digest_t digest,
                                    input status_e_t st, input int count, input int occ);
    plan_row_t row;
    row.cmd               = cmd;
    row.digest            = digest;
    row.typed             = 1'b1;
    row.outcome.status    = st;
    row.outcome.count     = REF_COUNT_W'(count);
    row.outcome.occupancy = OCCUPANCY_W'(occ);
    directed_plan.push_back(row);
  endfunction

  function automatic digest_t fill_key(input int i);
    return {64'(i), 64'h0, 64'h0, 64'hc0de_0000_0000_0000};
  endfunction

  function automatic void build_plan();
    add_typed(CMD_GET, K_A, STATUS_MISSING, 0, 0);
    add_typed(CMD_DEC, K_A, STATUS_MISSING, 0, 0);
    add_typed(CMD_UNUSED, K_A, STATUS_OK, 0, 0);
    add_typed(CMD_INC, K_ZERO, STATUS_OK, 1, 1);
    add_typed(CMD_INC, K_ONES, STATUS_OK, 1, 2);
    add_typed(CMD_INC, K_ZERO, STATUS_OK, 2, 2);
    add_typed(CMD_GET, K_ZERO, STATUS_OK, 2, 2);
    add_row(CMD_GET, K_A ^ digest_t'(1));
    add_row(CMD_INC, K_A);
    add_row(CMD_GET, K_A ^ digest_t'(1));
    add_row(CMD_GET, K_A ^ (digest_t'(1) << 64));
    add_row(CMD_GET, K_A ^ (digest_t'(1) << 255));
    add_row(CMD_INC, K_A ^ (digest_t'(1) << 255));
    add_row(CMD_DEC, K_A);
    add_row(CMD_DEC, K_ONES);
    add_row(CMD_DEC, K_ZERO);
    add_row(CMD_INC, K_A);
    for (int i = 0; i < ENTRIES; i++) begin
      add_row(CMD_INC, fill_key(i));
    end
    add_typed(CMD_INC, ~K_A, STATUS_FULL, 0, ENTRIES);
    add_typed(CMD_UNUSED, ~K_A, STATUS_OK, 0, ENTRIES);
    for (int i = 0; i < ENTRIES; i++) begin
      add_row(CMD_DEC, fill_key(i));
    end
    add_row(CMD_DEC, K_ZERO);
    add_row(CMD_DEC, K_A);
    add_row(CMD_DEC, K_A ^ (digest_t'(1) << 255));
  endfunction

  task automatic send_request(input logic [CMD_W-1:0] cmd, input digest_t digest,
                              input bit typed, input outcome_t typed_outcome);
    outcome_t predicted;
    int       gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    command   <= cmd;
    key_word0 <= digest[63:0];
    key_word1 <= digest[127:64];
    key_word2 <= digest[191:128];
    key_word3 <= digest[255:192];
    do begin
      @(posedge clk);
    end while (!in_ready);
    predicted = predict(cmd, digest);
    if (typed) begin
      pending_outcomes.push_back(typed_outcome);
    end else begin
      pending_outcomes.push_back(predicted);
    end
  endtask

  initial begin : stimulus
    int               pick;
    logic [CMD_W-1:0] cmd;
    bit               filling;
    rst       = 1'b1;
    in_valid  = 1'b0;
    command   = '0;
    key_word0 = '0;
    key_word1 = '0;
    key_word2 = '0;
    key_word3 = '0;
    for (int e = 0; e < ENTRIES; e++) begin
      shadow_keys[e]   = '0;
      shadow_counts[e] = '0;
      shadow_live[e]   = 1'b0;
    end
    for (int p = 0; p < POOL_SIZE; p++) begin
      if (p < POOL_SIZE / 2) begin
        key_pool[p] = {$urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom, $urandom};
      end else begin
        key_pool[p] = key_pool[p - POOL_SIZE / 2] ^
                      (digest_t'(1) << $urandom_range(0, KEY_W - 1));
      end
    end
    build_plan();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_plan[r]) begin
      send_request(directed_plan[r].cmd, directed_plan[r].digest,
                   directed_plan[r].typed, directed_plan[r].outcome);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      filling = ((n / BLOCK_ITEMS) % 2) == 0;
      pick    = $urandom_range(0, 99);
      if (pick < 5) begin
        cmd = CMD_UNUSED;
      end else if (pick < 25) begin
        cmd = CMD_GET;
      end else if (filling ? (pick < 85) : (pick < 45)) begin
        cmd = CMD_INC;
      end else begin
        cmd = CMD_DEC;
      end
      send_request(cmd, key_pool[$urandom_range(0, POOL_SIZE - 1)], 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (pending_outcomes.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : receiver
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_outcomes.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d count %0d occupancy %0d",
                 $time, status, ref_count, occupancy);
        errors++;
      end else begin
        expected_outcome = pending_outcomes.pop_front();
        if ((status !== expected_outcome.status) || (ref_count !== expected_outcome.count) ||
            (occupancy !== expected_outcome.occupancy)) begin
          $display("%0t: expected status %0d count %0d occupancy %0d, actual status %0d count %0d occupancy %0d",
                   $time, expected_outcome.status, expected_outcome.count,
                   expected_outcome.occupancy, status, ref_count, occupancy);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

endmodule
